>>> rtl/vrp_pkg.sv
// Package for the vertex rotate/project pipeline: payload types, widths,
// the quarter-wave sine table and small arithmetic helpers.
// No dependencies.
package vrp_pkg;

  localparam int TILE_SCALE      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QTR_LEN         = 1 << (SINE_TABLE_BITS - 2);
  localparam int IDX_W           = SINE_TABLE_BITS - 1;
  localparam logic [IDX_W-1:0] QTR_IDX = IDX_W'(QTR_LEN);

  localparam int CW  = 50;  // coordinate width through the rotations
  localparam int PW  = CW + 17;
  localparam int SW  = PW + 1;
  localparam int XW  = 72;  // scratch width for truncating shifts
  localparam int SCW = 48;  // projected coordinate width

  localparam logic [2:0] REG_CAM_COL    = 3'd0;
  localparam logic [2:0] REG_CAM_ROW    = 3'd1;
  localparam logic [2:0] REG_ZOOM       = 3'd2;
  localparam logic [2:0] REG_GAIN       = 3'd3;
  localparam logic [2:0] REG_ROT_ANGLES = 3'd4;
  localparam logic [2:0] REG_PROJ_ANGLE = 3'd5;
  localparam logic [2:0] REG_SCR_DX     = 3'd6;
  localparam logic [2:0] REG_SCR_DY     = 3'd7;

  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [9:0]         grid_col;
    logic [9:0]         grid_row;
    logic signed [15:0] height;
    logic [23:0]        colour_in;
  } in_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [23:0]        colour_out;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    logic [23:0]          colour;
  } rot_t;

  typedef struct packed {
    logic signed [16:0] sin_x;
    logic signed [16:0] cos_x;
    logic signed [16:0] sin_y;
    logic signed [16:0] cos_y;
    logic signed [16:0] sin_z;
    logic signed [16:0] cos_z;
    logic signed [16:0] sin_p;
    logic signed [16:0] cos_p;
  } trig_t;

  typedef logic [15:0] sine_tab_t [0:QTR_LEN];

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint unsigned x, x2, t, s, r;
    for (int i = 0; i <= QTR_LEN; i++) begin
      x  = (longint'(i) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      r  = (s + 64'd16384) >> 15;
      if (r > 64'd32767) r = 64'd32767;
      tab[i] = 16'(r);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  function automatic logic signed [16:0] sin_lookup(input logic [15:0] ang);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [IDX_W-1:0]           ri;
    logic signed [16:0]         val;
    idx  = ang[15 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    ri   = {1'b0, idx[SINE_TABLE_BITS-3:0]};
    if (quad[0]) ri = QTR_IDX - ri;
    val = $signed({1'b0, SINE_TAB[ri]});
    return quad[1] ? -val : val;
  endfunction

  // arithmetic shift right, rounding toward zero
  function automatic logic signed [XW-1:0] shr_trunc(input logic signed [XW-1:0] v,
                                                      input int sh);
    logic signed [XW-1:0] bias;
    bias = v[XW-1] ? $signed((XW'(1) << sh) - XW'(1)) : '0;
    return (v + bias) >>> sh;
  endfunction

  // one radix-256 digit of a divide by five: returns {quotient digit, remainder}
  function automatic logic [10:0] div5_step(input logic [2:0] rem, input logic [7:0] dig);
    logic [10:0] x;
    logic [7:0]  q;
    x = {rem, dig};
    q = 8'((25'(x) * 25'd13108) >> 16);
    return {q, 3'(x - 11'(q) * 11'd5)};
  endfunction

  // {saturated, value}
  function automatic logic [16:0] clamp16(input logic signed [SCW:0] v);
    if (v > $signed((SCW+1)'(32767))) return {1'b1, 16'h7fff};
    if (v < -$signed((SCW+1)'(32768))) return {1'b1, 16'h8000};
    return {1'b0, v[15:0]};
  endfunction

endpackage

>>> rtl/vertex_rotate_project.sv
// Vertex rotate/project top level: configuration registers, trig lookup,
// front end, Z/X/Y rotations and projection. Depends on vrp_pkg and submodules.
// Throughput: one vertex per cycle unless out_ready stalls the output.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults; the trig registers follow the angle registers in the next cycle.
module vertex_rotate_project (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vrp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output vrp_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_index,
  input  logic [47:0]   cfg_data
);
  import vrp_pkg::*;

  logic signed [20:0] cam_col_r, cam_row_r;
  logic [15:0]        zoom_r, gain_r, proj_angle_r;
  logic [47:0]        rot_angles_r;
  logic signed [15:0] scr_dx_r, scr_dy_r;

  trig_t trig;
  rot_t  f_item, z_item, x_item, y_item;
  logic  f_valid, f_ready, z_valid, z_ready, x_valid, x_ready, y_valid, y_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_col_r    <= '0;
      cam_row_r    <= '0;
      zoom_r       <= 16'd256;
      gain_r       <= 16'd3840;
      rot_angles_r <= '0;
      proj_angle_r <= 16'd5461;
      scr_dx_r     <= '0;
      scr_dy_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CAM_COL:    cam_col_r    <= cfg_data[20:0];
        REG_CAM_ROW:    cam_row_r    <= cfg_data[20:0];
        REG_ZOOM:       zoom_r       <= cfg_data[15:0];
        REG_GAIN:       gain_r       <= cfg_data[15:0];
        REG_ROT_ANGLES: rot_angles_r <= cfg_data;
        REG_PROJ_ANGLE: proj_angle_r <= cfg_data[15:0];
        REG_SCR_DX:     scr_dx_r     <= cfg_data[15:0];
        REG_SCR_DY:     scr_dy_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  vrp_trig u_trig (
    .clk        (clk),
    .rot_angles (rot_angles_r),
    .proj_angle (proj_angle_r),
    .trig       (trig)
  );

  vrp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_data),
    .cam_col     (cam_col_r),
    .cam_row     (cam_row_r),
    .zoom        (zoom_r),
    .height_gain (gain_r),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_item    (f_item)
  );

  // Z: (x, y) rotate, z passes
  vrp_rotate u_rot_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .sin_v     (trig.sin_z),
    .cos_v     (trig.cos_z),
    .out_valid (z_valid),
    .out_ready (z_ready),
    .out_item  (z_item)
  );

  // X: (y, z) rotate, x passes
  vrp_rotate u_rot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (z_valid),
    .in_ready  (z_ready),
    .in_item   ('{a: z_item.b, b: z_item.c, c: z_item.a, colour: z_item.colour}),
    .sin_v     (trig.sin_x),
    .cos_v     (trig.cos_x),
    .out_valid (x_valid),
    .out_ready (x_ready),
    .out_item  (x_item)
  );

  // Y: (z, x) rotate, y passes
  vrp_rotate u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (x_valid),
    .in_ready  (x_ready),
    .in_item   ('{a: x_item.b, b: x_item.c, c: x_item.a, colour: x_item.colour}),
    .sin_v     (trig.sin_y),
    .cos_v     (trig.cos_y),
    .out_valid (y_valid),
    .out_ready (y_ready),
    .out_item  (y_item)
  );

  vrp_project u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (y_valid),
    .in_ready  (y_ready),
    .in_item   (y_item),
    .sin_p     (trig.sin_p),
    .cos_p     (trig.cos_p),
    .scr_dx    (scr_dx_r),
    .scr_dy    (scr_dy_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

endmodule

>>> rtl/vrp_trig.sv
// Registered sine/cosine of the rotation and projection angles.
// Depends on vrp_pkg (sine table, lookup).
module vrp_trig (
  input  logic           clk,
  input  logic [47:0]    rot_angles,
  input  logic [15:0]    proj_angle,
  output vrp_pkg::trig_t trig
);
  import vrp_pkg::*;

  trig_t trig_r;

  always_ff @(posedge clk) begin
    trig_r.sin_x <= sin_lookup(rot_angles[15:0]);
    trig_r.cos_x <= sin_lookup(rot_angles[15:0] + 16'd16384);
    trig_r.sin_y <= sin_lookup(rot_angles[31:16]);
    trig_r.cos_y <= sin_lookup(rot_angles[31:16] + 16'd16384);
    trig_r.sin_z <= sin_lookup(rot_angles[47:32]);
    trig_r.cos_z <= sin_lookup(rot_angles[47:32] + 16'd16384);
    trig_r.sin_p <= sin_lookup(proj_angle);
    trig_r.cos_p <= sin_lookup(proj_angle + 16'd16384);
  end

  assign trig = trig_r;

endmodule

>>> rtl/vrp_front.sv
// Front end: tile scaling, centre and zoom of x/y, height scaling and the
// divide by five of z, four register stages. Depends on vrp_pkg.
module vrp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vrp_pkg::in_t        in_item,
  input  logic signed [20:0]  cam_col,
  input  logic signed [20:0]  cam_row,
  input  logic [15:0]         zoom,
  input  logic [15:0]         height_gain,
  output logic                out_valid,
  input  logic                out_ready,
  output vrp_pkg::rot_t       out_item
);
  import vrp_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [38:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic [32:0]        hz_r;
  logic               neg1_r, neg2_r, neg3_r;
  logic [23:0]        col1_r, col2_r, col3_r;
  logic [47:0]        n_r;
  logic [23:0]        qhi_r, nlo_r;
  logic [2:0]         rem_r;
  rot_t               out_r;

  logic signed [21:0] xd, yd;
  logic [16:0]        hmag;
  logic [56:0]        pt;
  logic [23:0]        qhi, qlo;
  logic [2:0]         rhi, rlo;
  logic [10:0]        st;
  logic [47:0]        q;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_comb begin
    xd   = 22'(in_item.grid_col * TILE_SCALE) - 22'(cam_col);
    yd   = 22'(in_item.grid_row * TILE_SCALE) - 22'(cam_row);
    hmag = in_item.height[15] ? (17'({1'b0, ~in_item.height}) + 17'd1)
                              : 17'({1'b0, in_item.height});
    pt   = 57'(hz_r) * 57'(height_gain) * 57'(TILE_SCALE);
    rhi  = 3'd0;
    qhi  = '0;
    for (int k = 0; k < 3; k++) begin
      st  = div5_step(rhi, n_r[47 - 8*k -: 8]);
      qhi[23 - 8*k -: 8] = st[10:3];
      rhi = st[2:0];
    end
    rlo = rem_r;
    qlo = '0;
    for (int k = 0; k < 3; k++) begin
      st  = div5_step(rlo, nlo_r[23 - 8*k -: 8]);
      qlo[23 - 8*k -: 8] = st[10:3];
      rlo = st[2:0];
    end
    q = {qhi_r, qlo};
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r   <= xd * $signed({1'b0, zoom});
      y1_r   <= yd * $signed({1'b0, zoom});
      hz_r   <= 33'(hmag) * 33'(zoom);
      neg1_r <= in_item.height[15];
      col1_r <= in_item.colour_in;
    end
    if (rdy2) begin
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      n_r    <= 48'(pt >> 8);
      neg2_r <= neg1_r;
      col2_r <= col1_r;
    end
    if (rdy3) begin
      x3_r   <= x2_r;
      y3_r   <= y2_r;
      qhi_r  <= qhi;
      rem_r  <= rhi;
      nlo_r  <= n_r[23:0];
      neg3_r <= neg2_r;
      col3_r <= col2_r;
    end
    if (rdy4) begin
      out_r.a      <= CW'(x3_r);
      out_r.b      <= CW'(y3_r);
      out_r.c      <= neg3_r ? -$signed(CW'(q)) : $signed(CW'(q));
      out_r.colour <= col3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = out_r;

endmodule

>>> rtl/vrp_rotate.sv
// One planar rotation: a' = a*cos - b*sin, b' = a*sin + b*cos, c passes.
// Two register stages (products, then sums). Depends on vrp_pkg.
module vrp_rotate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vrp_pkg::rot_t      in_item,
  input  logic signed [16:0] sin_v,
  input  logic signed [16:0] cos_v,
  output logic               out_valid,
  input  logic               out_ready,
  output vrp_pkg::rot_t      out_item
);
  import vrp_pkg::*;

  logic va_r, vb_r, rdy_a, rdy_b;
  logic signed [PW-1:0] ac_r, bs_r, as_r, bc_r;
  logic signed [CW-1:0] c_r;
  logic [23:0]          col_r;
  rot_t                 out_r;
  logic signed [SW-1:0] sum_a, sum_b;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  assign sum_a = SW'(ac_r) - SW'(bs_r);
  assign sum_b = SW'(as_r) + SW'(bc_r);

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      ac_r  <= PW'(in_item.a) * PW'(cos_v);
      bs_r  <= PW'(in_item.b) * PW'(sin_v);
      as_r  <= PW'(in_item.a) * PW'(sin_v);
      bc_r  <= PW'(in_item.b) * PW'(cos_v);
      c_r   <= in_item.c;
      col_r <= in_item.colour;
    end
    if (rdy_b) begin
      out_r.a      <= CW'(shr_trunc(XW'(sum_a), 15));
      out_r.b      <= CW'(shr_trunc(XW'(sum_b), 15));
      out_r.c      <= c_r;
      out_r.colour <= col_r;
    end
  end

  assign out_valid = vb_r;
  assign out_item  = out_r;

endmodule

>>> rtl/vrp_project.sv
// Isometric projection, screen offsets and saturation; four register
// stages, the last one is the output register. Depends on vrp_pkg.
module vrp_project (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vrp_pkg::rot_t      in_item,   // a = z, b = x, c = y
  input  logic signed [16:0] sin_p,
  input  logic signed [16:0] cos_p,
  input  logic signed [15:0] scr_dx,
  input  logic signed [15:0] scr_dy,
  output logic               out_valid,
  input  logic               out_ready,
  output vrp_pkg::out_t      out_item
);
  import vrp_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [CW:0]    d_r, s_r;
  logic signed [CW-1:0]  z1_r, z2_r;
  logic signed [XW-1:0]  pd_r, ps_r;
  logic signed [SCW-1:0] sx_r, sy_r;
  logic [23:0]           col1_r, col2_r, col3_r;
  out_t                  out_r;
  logic [16:0]           cx, cy;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign cx = clamp16((SCW+1)'(sx_r) + (SCW+1)'(scr_dx));
  assign cy = clamp16((SCW+1)'(sy_r) + (SCW+1)'(scr_dy));

  always_ff @(posedge clk) begin
    if (rdy1) begin
      d_r    <= (CW+1)'(in_item.b) - (CW+1)'(in_item.c);
      s_r    <= (CW+1)'(in_item.b) + (CW+1)'(in_item.c);
      z1_r   <= in_item.a;
      col1_r <= in_item.colour;
    end
    if (rdy2) begin
      pd_r   <= XW'(d_r) * XW'(cos_p);
      ps_r   <= XW'(s_r) * XW'(sin_p);
      z2_r   <= z1_r;
      col2_r <= col1_r;
    end
    if (rdy3) begin
      sx_r   <= SCW'(shr_trunc(pd_r, 23));
      sy_r   <= SCW'(shr_trunc(ps_r - (XW'(z2_r) <<< 15), 23));
      col3_r <= col2_r;
    end
    if (rdy4) begin
      out_r.screen_x   <= cx[15:0];
      out_r.screen_y   <= cy[15:0];
      out_r.colour_out <= col3_r;
      out_r.saturated  <= cx[16] | cy[16];
    end
  end

  assign out_valid = v4_r;
  assign out_item  = out_r;

endmodule

>>> tb/vertex_rotate_project_tb.sv
// Self-checking testbench for vertex_rotate_project: predicts each projected
// vertex in fixed point and checks results in order. Depends on vrp_pkg.
`timescale 1ns / 1ps

module vertex_rotate_project_tb;
  import vrp_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 40;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_t         in_data;
  out_t        out_data;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  vertex_rotate_project dut (.*);

  longint signed   cx, cy, ox, oy;
  longint unsigned zm, hg, rot, pang;
  int              qlut [0:QTR_LEN];

  in_t   pending [$];
  out_t  expected_pts [$];
  int    errors = 0, n_out = 0, n_sat = 0, cycles = 0;
  int    hold_cnt = 0;
  bit    in_taken = 0;
  int    burst = 0, gap = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("vertex_rotate_project verification failed");
      $finish;
    end
  end

  function automatic void make_lut();
    longint unsigned x, x2, t, s, r;
    for (int i = 0; i <= QTR_LEN; i++) begin
      x  = (longint'(i) * 64'd1686629713) >> (SINE_TABLE_BITS - 2);
      x2 = (x * x) >> 30;
      t  = (64'd1 << 30) - x2 / 110;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      r  = (s + 16384) >> 15;
      qlut[i] = (r > 32767) ? 32767 : int'(r);
    end
  endfunction

  function automatic longint signed sine_of(logic [15:0] a);
    int idx, quad, r;
    idx  = a >> (16 - SINE_TABLE_BITS);
    quad = (idx >> (SINE_TABLE_BITS - 2)) & 3;
    r    = idx & (QTR_LEN - 1);
    case (quad)
      0: return qlut[r];
      1: return qlut[QTR_LEN - r];
      2: return -qlut[r];
      default: return -qlut[QTR_LEN - r];
    endcase
  endfunction

  function automatic longint signed cosine_of(logic [15:0] a);
    return sine_of(a + 16'd16384);
  endfunction

  function automatic longint signed tdiv(longint signed v, int sh);
    if (v < 0) return -((-v) >>> sh);
    return v >>> sh;
  endfunction

  function automatic out_t project_vertex(in_t v);
    out_t o;
    longint signed sx, cxr, sy, cyr, sz, czr, sp, cp;
    longint signed x0, y0, z0, x1, y1, y2, z1, x2, z2, px, py, h;
    longint unsigned hm;
    sx = sine_of(rot[15:0]);   cxr = cosine_of(rot[15:0]);
    sy = sine_of(rot[31:16]);  cyr = cosine_of(rot[31:16]);
    sz = sine_of(rot[47:32]);  czr = cosine_of(rot[47:32]);
    sp = sine_of(pang[15:0]);  cp = cosine_of(pang[15:0]);
    x0 = (longint'(v.grid_col) * TILE_SCALE - cx) * longint'(zm);
    y0 = (longint'(v.grid_row) * TILE_SCALE - cy) * longint'(zm);
    h  = v.height;
    hm = (h < 0) ? -h : h;
    hm = (hm * zm * hg * TILE_SCALE) / 1280;
    z0 = (h < 0) ? -longint'(hm) : longint'(hm);
    x1 = tdiv(x0 * czr - y0 * sz, 15);
    y1 = tdiv(x0 * sz + y0 * czr, 15);
    y2 = tdiv(y1 * cxr - z0 * sx, 15);
    z1 = tdiv(y1 * sx + z0 * cxr, 15);
    x2 = tdiv(x1 * cyr + z1 * sy, 15);
    z2 = tdiv(z1 * cyr - x1 * sy, 15);
    px = tdiv((x2 - y2) * cp, 23) + ox;
    py = tdiv((x2 + y2) * sp - z2 * 32768, 23) + oy;
    o.saturated = 0;
    if (px > 32767) begin px = 32767; o.saturated = 1; end
    if (px < -32768) begin px = -32768; o.saturated = 1; end
    if (py > 32767) begin py = 32767; o.saturated = 1; end
    if (py < -32768) begin py = -32768; o.saturated = 1; end
    o.screen_x = px[15:0];
    o.screen_y = py[15:0];
    o.colour_out = v.colour_in;
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_out);
    errors++;
  endtask

  // input transfer seen at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_valid && !in_taken) begin
    end else begin
      if (in_valid) void'(pending.pop_front());
      if (gap > 0) begin
        gap--;
        in_valid <= 0;
      end else if (pending.size() > 0) begin
        in_valid <= 1;
        in_data <= pending[0];
        if (burst > 0) burst--;
        else begin
          burst = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // predictor, fed by input transfers
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) expected_pts.push_back(project_vertex(in_data));
  end

  // receiver stall pattern, with a long hold-off counted here
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 0;
    end else begin
      out_ready <= (cycles % 97 < 60) ? 1 : ($urandom_range(0, 2) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pts.size() == 0) begin
        $display("unexpected result %0d", n_out);
        errors++;
      end else begin
        w = expected_pts.pop_front();
        if (out_data.screen_x !== w.screen_x) report("screen_x", out_data.screen_x, w.screen_x);
        if (out_data.screen_y !== w.screen_y) report("screen_y", out_data.screen_y, w.screen_y);
        if (out_data.colour_out !== w.colour_out)
          report("colour_out", out_data.colour_out, w.colour_out);
        if (out_data.saturated !== w.saturated)
          report("saturated", out_data.saturated, w.saturated);
        if (w.saturated) n_sat++;
      end
      n_out++;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    case (idx)
      REG_CAM_COL:    cx = longint'($signed(val[20:0]));
      REG_CAM_ROW:    cy = longint'($signed(val[20:0]));
      REG_ZOOM:       zm = val[15:0];
      REG_GAIN:       hg = val[15:0];
      REG_ROT_ANGLES: rot = val;
      REG_PROJ_ANGLE: pang = val[15:0];
      REG_SCR_DX:     ox = longint'($signed(val[15:0]));
      default:        oy = longint'($signed(val[15:0]));
    endcase
    repeat (3) @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || in_valid || expected_pts.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic in_t vertex(int c, int r, int h, int col);
    in_t v;
    v.grid_col = 10'(c); v.grid_row = 10'(r); v.height = 16'(h); v.colour_in = 24'(col);
    return v;
  endfunction

  function automatic in_t rand_vertex(bit near);
    in_t v;
    v.grid_col  = near ? 10'($urandom_range(0, 63)) : 10'($urandom);
    v.grid_row  = near ? 10'($urandom_range(0, 63)) : 10'($urandom);
    v.height    = near ? 16'(int'($urandom_range(0, 400)) - 200) : 16'($urandom);
    v.colour_in = 24'($urandom);
    return v;
  endfunction

  task automatic load_random_cfg(int phase);
    write_reg(REG_CAM_COL, (phase % 2) ? 48'($urandom_range(0, 2047)) : 48'($urandom));
    write_reg(REG_CAM_ROW, (phase % 2) ? 48'($urandom_range(0, 2047)) : 48'($urandom));
    write_reg(REG_ZOOM, (phase % 3 == 0) ? 16'($urandom) : 16'($urandom_range(16, 512)));
    write_reg(REG_GAIN, 16'($urandom_range(0, 65535) >> $urandom_range(0, 8)));
    write_reg(REG_ROT_ANGLES, {16'($urandom), 16'($urandom), 16'($urandom)});
    write_reg(REG_PROJ_ANGLE, 16'($urandom));
    write_reg(REG_SCR_DX, 16'($urandom));
    write_reg(REG_SCR_DY, 16'($urandom));
  endtask

  initial begin
    make_lut();
    cx = 0; cy = 0; zm = 256; hg = 3840; rot = 0; pang = 5461; ox = 0; oy = 0;
    rst_n = 0; cfg_wr_en = 0; cfg_index = REG_CAM_COL; cfg_data = '0;
    in_valid = 0; in_data = '0; out_ready = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1;
    repeat (4) @(negedge clk);

    // directed at reset defaults
    pending.push_back(vertex(0, 0, 0, 0));
    pending.push_back(vertex(1023, 1023, 32767, 24'hffffff));
    pending.push_back(vertex(0, 1023, -32768, 24'h123456));
    pending.push_back(vertex(1023, 0, 1, 24'h800000));
    pending.push_back(vertex(5, 7, -1, 24'h00ff00));
    wait_idle();
    // extreme settings: saturation and wrap
    write_reg(REG_ZOOM, 16'hffff);
    write_reg(REG_GAIN, 16'hffff);
    write_reg(REG_CAM_COL, 48'h100000);
    write_reg(REG_CAM_ROW, 48'h0fffff);
    write_reg(REG_ROT_ANGLES, 48'hffff_8000_4000);
    write_reg(REG_PROJ_ANGLE, 16'hffff);
    write_reg(REG_SCR_DX, 16'h7fff);
    write_reg(REG_SCR_DY, 16'h8000);
    pending.push_back(vertex(1023, 1023, 32767, 24'haaaaaa));
    pending.push_back(vertex(0, 0, -32768, 24'h555555));
    pending.push_back(vertex(512, 300, 100, 24'h0f0f0f));
    wait_idle();
    write_reg(REG_ZOOM, 16'h0);
    pending.push_back(vertex(1023, 1023, 32767, 24'h111111));
    pending.push_back(vertex(3, 900, -500, 24'h222222));
    wait_idle();
    // dead-center view
    write_reg(REG_ZOOM, 16'd256);
    write_reg(REG_GAIN, 16'd0);
    write_reg(REG_CAM_COL, 48'd0);
    write_reg(REG_CAM_ROW, 48'd0);
    write_reg(REG_ROT_ANGLES, 48'd0);
    write_reg(REG_PROJ_ANGLE, 16'd0);
    write_reg(REG_SCR_DX, 16'd0);
    write_reg(REG_SCR_DY, 16'd0);
    pending.push_back(vertex(10, 20, 30000, 24'h333333));
    pending.push_back(vertex(1023, 0, -30000, 24'h444444));
    wait_idle();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      load_random_cfg(ph);
      for (int i = 0; i < 105; i++)
        pending.push_back(rand_vertex($urandom_range(0, 3) != 0));
      if (ph == 2) hold_cnt = 200;
      wait_idle();
    end

    $display("covered %0d results, %0d saturated, over 10 register settings", n_out, n_sat);
    if (errors == 0) $display("vertex_rotate_project verification clean");
    else $display("vertex_rotate_project verification failed");
    $finish;
  end
endmodule

>>> sim.f
rtl/vrp_pkg.sv
rtl/vrp_trig.sv
rtl/vrp_front.sv
rtl/vrp_rotate.sv
rtl/vrp_project.sv
rtl/vertex_rotate_project.sv
tb/vertex_rotate_project_tb.sv
